FILE: rtl/blbc_pkg.sv
`default_nettype none
package blbc_pkg;

   localparam int ENTRIES = 32;
   localparam int KEY_W   = 64;
   localparam int SIZE_W  = 31;
   localparam int RANK_W  = $clog2(ENTRIES);
   localparam int LIVE_W  = $clog2(ENTRIES + 1);

   localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1048576);

   localparam logic REQ_ACCESS = 1'b0;
   localparam logic REQ_FILL   = 1'b1;

   localparam logic [2:0] CSR_CAP_ADDR = 3'd0;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_MISS      = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_REFRESHED = 3'd3,
      ST_REJECTED  = 3'd4,
      ST_EVICTED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_TOUCH,
      OP_INSERT,
      OP_EVICT
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_FILL
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type       op;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
      logic [RANK_W-1:0] touch_rank;
      logic [RANK_W-1:0] victim_rank;
   } cell_cmd_type;

   // passed from cell i to cell i+1; lowest index claims first
   typedef struct packed {
      logic              found_match;
      logic [RANK_W-1:0] match_rank;
      logic              found_free;
      logic              found_victim;
      logic [KEY_W-1:0]  victim_key;
      logic [SIZE_W-1:0] victim_size;
   } chain_type;

endpackage
`default_nettype wire

FILE: rtl/blbc_cell.sv
`default_nettype none
module blbc_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire blbc_pkg::cell_cmd_type cmd,
   input  wire blbc_pkg::chain_type    chain_in,
   output blbc_pkg::chain_type      chain_out
);
   import blbc_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [RANK_W-1:0] rank_ff, rank_in;

   logic hit, victim, sel_hit, sel_free, sel_victim;

   assign hit        = valid_ff && (key_ff == cmd.key);
   assign victim     = valid_ff && (rank_ff == cmd.victim_rank);
   assign sel_hit    = hit && !chain_in.found_match;
   assign sel_free   = !valid_ff && !chain_in.found_free;
   assign sel_victim = victim && !chain_in.found_victim;

   always_comb begin
      chain_out              = chain_in;
      chain_out.found_match  = chain_in.found_match | hit;
      chain_out.found_free   = chain_in.found_free | !valid_ff;
      chain_out.found_victim = chain_in.found_victim | victim;
      if (sel_hit) begin
         chain_out.match_rank = rank_ff;
      end
      if (sel_victim) begin
         chain_out.victim_key  = key_ff;
         chain_out.victim_size = size_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      size_in  = size_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         OP_TOUCH: begin
            if (sel_hit) begin
               rank_in = '0;
            end else if (valid_ff && rank_ff < cmd.touch_rank) begin
               rank_in = RANK_W'(rank_ff + 1'b1);
            end
         end
         OP_INSERT: begin
            if (valid_ff) begin
               rank_in = RANK_W'(rank_ff + 1'b1);
            end else if (sel_free) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               size_in  = cmd.size;
               rank_in  = '0;
            end
         end
         OP_EVICT: begin
            if (sel_victim) begin
               valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      size_ff <= size_in;
      rank_ff <= rank_in;
   end

endmodule
`default_nettype wire

FILE: rtl/byte_budget_lru_cache.sv
`default_nettype none
// Size-aware LRU cache directory. Up to ENTRIES objects (64-bit key, 31-bit
// byte size) live in a row of cells, each holding one slot and its recency
// rank (0 = most recent). An access (req_type 0) answers hit or miss in one
// result and refreshes a hit. A fill (req_type 1) refreshes a present key,
// rejects a size above capacity_bytes, or evicts least recent entries, one
// result each, until the size fits and a slot is free, then inserts; the
// final result of every request carries rsp_last. An access, a refreshed
// fill and a rejected fill are accepted, then answered after a parallel key
// match over the cell row; a fill that inserts evicts as needed, one entry
// per cycle while no result is stalled, then inserts. Requests are handled
// one at a time; the result register lets the next request enter while a
// result still waits. capacity_bytes sits at address 0 of the APB port;
// the user must write it only while idle, which the block does not enforce;
// bytes in use are kept across a capacity change that still covers them.
module byte_budget_lru_cache (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_type,
   input  wire  [blbc_pkg::KEY_W-1:0]  req_key,
   input  wire  [blbc_pkg::SIZE_W-1:0] req_object_size,
   // response channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [blbc_pkg::KEY_W-1:0]  rsp_result_key,
   output logic [blbc_pkg::SIZE_W-1:0] rsp_bytes_free,
   output logic                       rsp_last,
   // config port
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire  [2:0]                 paddr,
   input  wire  [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import blbc_pkg::*;

   state_type state_ff, state_in;

   logic              rtype_ff;
   logic [KEY_W-1:0]  rkey_ff;
   logic [SIZE_W-1:0] rsize_ff;

   logic [SIZE_W-1:0] cap_ff, cap_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [LIVE_W-1:0] live_ff, live_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [SIZE_W-1:0] rsp_free_ff, rsp_free_in;
   logic              rsp_last_ff, rsp_last_in;

   cell_cmd_type cmd;
   chain_type    chain [0:ENTRIES];

   logic              accept, out_free, cfg_wr, need_evict;
   logic [SIZE_W:0]   evict_sum;
   logic [SIZE_W-1:0] evict_free, used, new_cap;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr   = psel && penable && pwrite && (paddr == CSR_CAP_ADDR);

   assign req_stall = (state_ff != S_IDLE);
   assign pready    = 1'b1;
   assign prdata    = (paddr == CSR_CAP_ADDR) ? {1'b0, cap_ff} : 32'd0;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_key = rsp_key_ff;
   assign rsp_bytes_free = rsp_free_ff;
   assign rsp_last       = rsp_last_ff;

   // cell row, lowest index first in the chain
   assign chain[0] = '0;
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      blbc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .chain_in (chain[i]),
         .chain_out(chain[i+1])
      );
   end

   // least recent entry holds rank live-1
   assign evict_sum  = {1'b0, free_ff} + {1'b0, chain[ENTRIES].victim_size};
   assign evict_free = (live_ff == LIVE_W'(1)) ? cap_ff :
                       (evict_sum > {1'b0, cap_ff}) ? cap_ff : evict_sum[SIZE_W-1:0];
   assign need_evict = (live_ff != '0) &&
                       ((rsize_ff > free_ff) || (live_ff >= LIVE_W'(ENTRIES)));

   assign new_cap = pwdata[SIZE_W-1:0];
   assign used    = (cap_ff >= free_ff) ? SIZE_W'(cap_ff - free_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      free_in       = free_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_last_in   = rsp_last_ff;

      cmd.op          = OP_NONE;
      cmd.key         = rkey_ff;
      cmd.size        = rsize_ff;
      cmd.touch_rank  = chain[ENTRIES].match_rank;
      cmd.victim_rank = RANK_W'(live_ff - 1'b1);

      if (cfg_wr) begin
         cap_in  = new_cap;
         free_in = (live_ff == '0) ? new_cap :
                   (new_cap > used) ? SIZE_W'(new_cap - used) : '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = rkey_ff;
               rsp_free_in  = free_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (chain[ENTRIES].found_match) begin
                  cmd.op        = OP_TOUCH;
                  rsp_status_in = (rtype_ff == REQ_ACCESS) ? ST_HIT : ST_REFRESHED;
               end else if (rtype_ff == REQ_ACCESS) begin
                  rsp_status_in = ST_MISS;
               end else if (rsize_ff > cap_ff) begin
                  rsp_status_in = ST_REJECTED;
               end else begin
                  // fill goes on to eviction / insert
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
                  rsp_last_in  = rsp_last_ff;
                  rsp_key_in   = rsp_key_ff;
                  rsp_free_in  = rsp_free_ff;
                  state_in     = S_FILL;
               end
            end
         end
         S_FILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (need_evict) begin
                  cmd.op        = OP_EVICT;
                  live_in       = LIVE_W'(live_ff - 1'b1);
                  free_in       = evict_free;
                  rsp_status_in = ST_EVICTED;
                  rsp_key_in    = chain[ENTRIES].victim_key;
                  rsp_free_in   = evict_free;
                  rsp_last_in   = 1'b0;
               end else begin
                  cmd.op        = OP_INSERT;
                  live_in       = LIVE_W'(live_ff + 1'b1);
                  free_in       = SIZE_W'(free_ff - rsize_ff);
                  rsp_status_in = ST_INSERTED;
                  rsp_key_in    = rkey_ff;
                  rsp_free_in   = SIZE_W'(free_ff - rsize_ff);
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         free_ff      <= CAP_RESET;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         free_ff      <= free_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rtype_ff <= req_type;
         rkey_ff  <= req_key;
         rsize_ff <= req_object_size;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // occupancy never exceeds the table
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(ENTRIES))
      else $error("live count above table size");

   // free bytes never exceed the budget
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= cap_ff)
      else $error("free budget above capacity");

   // empty table owns the whole budget
   a_empty_free: assert property (@(posedge clock) disable iff (reset)
      (live_ff == '0) |-> (free_ff == cap_ff))
      else $error("empty table with partial budget");

   // an insert always fits and always finds a slot
   a_insert_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INSERT) |-> (rsize_ff <= free_ff && chain[ENTRIES].found_free))
      else $error("insert without room");

endmodule
`default_nettype wire
